// ===== rtl/mcqc_pkg.sv =====
// ----------------------------------------------------------------------------
// mcqc_pkg
// Shared types and constants for the multi-channel quadrature counter.
// ----------------------------------------------------------------------------
package mcqc_pkg;

    localparam int unsigned MODE_W     = 2;
    localparam int unsigned LEVEL_BITS = 3;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned SEL_W      = 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_SAMPLE = 2'd0,
        MODE_SELECT = 2'd1,
        MODE_READ   = 2'd2
    } mode_t;

    // Decoded command of one accepted item
    typedef struct packed {
        logic sample;
        logic select;
        logic read;
    } cmd_t;

endpackage

// ===== rtl/multi_channel_quadrature_counter.sv =====
// ----------------------------------------------------------------------------
// multi_channel_quadrature_counter
// Multi-channel x4 quadrature decoder with selectable count readout.
// ----------------------------------------------------------------------------
//   channel | ports                                        | direction
//   --------+----------------------------------------------+----------
//   input   | s_valid s_ready s_mode s_a_levels s_b_levels |  in
//           | s_channel_select                             |
//   result  | m_valid m_ready m_count_high m_count_low     |  out
//           | m_bad_select                                 |
//
// One item per cycle while s_ready is high. Each lane updates when a sample item
// is accepted; a read item's result appears in the result register next cycle.
// s_ready drops only while a result waits and m_ready is low; the register
// frees and refills in the same cycle. Synchronous active-low reset clears
// counts, stored levels, the primed flag and the channel selection.
// ----------------------------------------------------------------------------
module multi_channel_quadrature_counter #(
    parameter int unsigned CHANNELS    = 3,
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [mcqc_pkg::MODE_W-1:0]           s_mode,
    input  logic [mcqc_pkg::LEVEL_BITS-1:0]       s_a_levels,
    input  logic [mcqc_pkg::LEVEL_BITS-1:0]       s_b_levels,
    input  logic [mcqc_pkg::SEL_W-1:0]            s_channel_select,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [mcqc_pkg::BYTE_W-1:0]           m_count_high,
    output logic [mcqc_pkg::BYTE_W-1:0]           m_count_low,
    output logic                                  m_bad_select
);

    logic                                 accept;
    logic                                 out_free;
    logic                                 primed_reg;
    mcqc_pkg::cmd_t                       cmd;
    logic [CHANNELS-1:0][COUNT_WIDTH-1:0] counts;

    assign s_ready = out_free;
    assign accept  = s_valid && s_ready;

    always_comb begin
        cmd = '0;
        if (accept) begin
            unique case (mcqc_pkg::mode_t'(s_mode))
                mcqc_pkg::MODE_SAMPLE: cmd.sample = 1'b1;
                mcqc_pkg::MODE_SELECT: cmd.select = 1'b1;
                mcqc_pkg::MODE_READ:   cmd.read   = 1'b1;
                default:               cmd        = '0;
            endcase
        end
    end

    // First sample only records levels
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            primed_reg <= 1'b0;
        end else if (cmd.sample) begin
            primed_reg <= 1'b1;
        end
    end

    for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
        logic a_bit;
        logic b_bit;
        if (ch < mcqc_pkg::LEVEL_BITS) begin : g_pin
            assign a_bit = s_a_levels[ch];
            assign b_bit = s_b_levels[ch];
        end else begin : g_tie
            assign a_bit = 1'b0;
            assign b_bit = 1'b0;
        end

        mcqc_lane #(
            .COUNT_WIDTH(COUNT_WIDTH)
        ) u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .sample_en (cmd.sample),
            .primed    (primed_reg),
            .a_level   (a_bit),
            .b_level   (b_bit),
            .count     (counts[ch])
        );
    end

    mcqc_merge #(
        .CHANNELS    (CHANNELS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_merge (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .channel_select (s_channel_select),
        .counts         (counts),
        .out_free       (out_free),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_count_high   (m_count_high),
        .m_count_low    (m_count_low),
        .m_bad_select   (m_bad_select)
    );

endmodule

// ===== rtl/mcqc_lane.sv =====
// ----------------------------------------------------------------------------
// mcqc_lane
// One channel of x4 quadrature decoding: edge detect and wrapping count.
// ----------------------------------------------------------------------------
module mcqc_lane #(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   sample_en,
    input  logic                   primed,
    input  logic                   a_level,
    input  logic                   b_level,
    output logic [COUNT_WIDTH-1:0] count
);

    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic                   last_a_reg;
    logic                   last_b_reg;
    logic                   a_changed;
    logic                   b_changed;
    logic                   same;
    logic                   step_up;

    assign a_changed = a_level != last_a_reg;
    assign b_changed = b_level != last_b_reg;
    assign same      = a_level == b_level;
    // A alone: up when levels differ; B alone: up when levels match.
    // Both changing cancel out.
    assign step_up   = a_changed ? !same : same;

    always_comb begin
        count_next = count_reg;
        if (primed && (a_changed ^ b_changed)) begin
            if (step_up) begin
                count_next = count_reg + COUNT_WIDTH'(1);
            end else begin
                count_next = count_reg - COUNT_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            last_a_reg <= 1'b0;
            last_b_reg <= 1'b0;
        end else if (sample_en) begin
            count_reg  <= count_next;
            last_a_reg <= a_level;
            last_b_reg <= b_level;
        end
    end

    assign count = count_reg;

endmodule

// ===== rtl/mcqc_merge.sv =====
// ----------------------------------------------------------------------------
// mcqc_merge
// Channel selection, readout mux across lanes and the result register.
// ----------------------------------------------------------------------------
module mcqc_merge #(
    parameter int unsigned CHANNELS    = 3,
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  mcqc_pkg::cmd_t                           cmd,
    input  logic [mcqc_pkg::SEL_W-1:0]               channel_select,
    input  logic [CHANNELS-1:0][COUNT_WIDTH-1:0]     counts,
    output logic                                     out_free,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic [mcqc_pkg::BYTE_W-1:0]              m_count_high,
    output logic [mcqc_pkg::BYTE_W-1:0]              m_count_low,
    output logic                                     m_bad_select
);

    localparam int unsigned EXT_W =
        (COUNT_WIDTH < 2 * mcqc_pkg::BYTE_W) ? 2 * mcqc_pkg::BYTE_W : COUNT_WIDTH;

    logic [mcqc_pkg::SEL_W-1:0]  sel_reg;
    logic                        m_valid_reg;
    logic [mcqc_pkg::BYTE_W-1:0] high_reg;
    logic [mcqc_pkg::BYTE_W-1:0] low_reg;
    logic                        bad_reg;
    logic [EXT_W-1:0]            picked;
    logic                        hit;

    // Index mux over the lanes; no hit means the index names no channel
    always_comb begin
        picked = '0;
        hit    = 1'b0;
        for (int i = 0; i < CHANNELS; i++) begin
            if (sel_reg == mcqc_pkg::SEL_W'(i)) begin
                picked = EXT_W'(counts[i]);
                hit    = 1'b1;
            end
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.select) begin
                sel_reg <= channel_select;
            end
            if (cmd.read) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.read) begin
            high_reg <= picked[2*mcqc_pkg::BYTE_W-1:mcqc_pkg::BYTE_W];
            low_reg  <= picked[mcqc_pkg::BYTE_W-1:0];
            bad_reg  <= !hit;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_count_high = high_reg;
    assign m_count_low  = low_reg;
    assign m_bad_select = bad_reg;

endmodule
